// ----- hdl/sql_lex_pkg.sv -----
// Shared types, codes and the keyword table of the SQL lexer.
// No dependencies; the lexer top level refers to it by scoped names.
`default_nettype none

package sql_lex_pkg;

  localparam int unsigned MAX_QUERY_LEN_DEF = 4096;
  localparam int unsigned START_W = 12;
  localparam int unsigned LEN_W = 13;
  localparam int unsigned PREFIX_N = 6;
  localparam int unsigned KW_N = 16;
  localparam int unsigned OUT_DEPTH = 3;

  // token classes
  localparam logic [3:0] CLS_KW = 4'd0;
  localparam logic [3:0] CLS_OP = 4'd1;
  localparam logic [3:0] CLS_NUM = 4'd2;
  localparam logic [3:0] CLS_STR = 4'd3;
  localparam logic [3:0] CLS_COMMA = 4'd4;
  localparam logic [3:0] CLS_SEMI = 4'd5;
  localparam logic [3:0] CLS_LPAREN = 4'd6;
  localparam logic [3:0] CLS_RPAREN = 4'd7;
  localparam logic [3:0] CLS_IDENT = 4'd8;
  localparam logic [3:0] CLS_UNKNOWN = 4'd9;
  localparam logic [3:0] CLS_END = 4'd10;

  // operator ids
  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_EQ = 4'd4;
  localparam logic [3:0] OP_NE = 4'd5;
  localparam logic [3:0] OP_LT = 4'd6;
  localparam logic [3:0] OP_GT = 4'd7;
  localparam logic [3:0] OP_LE = 4'd8;
  localparam logic [3:0] OP_GE = 4'd9;
  localparam logic [3:0] OP_MOD = 4'd10;

  // characters with a role of their own
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // keyword text, first character in the top byte, padded with zero bytes
  localparam logic [8*PREFIX_N-1:0] KW_TEXT [KW_N] = '{
    "SELECT", {"FROM", 16'h0}, {"WHERE", 8'h0}, "INSERT",
    "UPDATE", "DELETE", {"ORDER", 8'h0}, {"BY", 32'h0},
    {"ASC", 24'h0}, {"DESC", 16'h0}, {"LIMIT", 8'h0}, {"INTO", 16'h0},
    "VALUES", {"SET", 24'h0}, {"AND", 24'h0}, {"OR", 32'h0}
  };
  localparam logic [LEN_W-1:0] KW_LEN [KW_N] = '{
    13'd6, 13'd4, 13'd5, 13'd6, 13'd6, 13'd6, 13'd5, 13'd2,
    13'd3, 13'd4, 13'd5, 13'd4, 13'd6, 13'd3, 13'd3, 13'd2
  };

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_STR
  } mode_e;

  typedef enum logic [2:0] {
    PEND_NONE,
    PEND_LT,
    PEND_GT,
    PEND_EQ,
    PEND_BANG
  } pend_e;

  typedef struct packed {
    mode_e                   mode;
    logic [8*PREFIX_N-1:0]   prefix;
    logic [LEN_W-1:0]        len;
    logic [START_W-1:0]      start;
    logic                    digits;
    logic                    ident;
  } word_t;

  typedef struct packed {
    logic [3:0]          cls;
    logic [3:0]          kw;
    logic [3:0]          op;
    logic [START_W-1:0]  start;
    logic [LEN_W-1:0]    len;
    logic                last_query;
    logic                last_step;
  } tok_t;

endpackage

`default_nettype wire

// ----- hdl/sql_query_lexer_unit.sv -----
// Streaming SQL lexer: byte in, tokens out, with a three-entry token queue.
// Depends on sql_lex_pkg for codes, the keyword table and the state types.
//
// One query byte is taken per clock while s_axis_tready is high: the byte
// and the lexer state go through one pass of character checks, the keyword
// compare and a one-byte operator lookahead, and the tokens it yields (none,
// one or two) land in a three-entry output queue in the same cycle. The
// output side drains one token per clock while m_axis_tready is high; a byte
// that yields two tokens can hold the input back, as s_axis_tready is high
// only while the queue holds at most one token. An s_axis_tlast byte closes
// the query: pending text is flushed, the last token carries m_axis_tlast,
// and an end token is sent if that byte yields nothing else. Offsets
// saturate at MAX_QUERY_LEN-1 and lengths at MAX_QUERY_LEN.
`default_nettype none

module sql_query_lexer_unit #(
  parameter int unsigned MAX_QUERY_LEN = sql_lex_pkg::MAX_QUERY_LEN_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] query_byte
  input  wire logic        s_axis_tlast,   // end_of_query
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [3:0] keyword_id, [7:4] operator_id, [19:8] start_offset,
  // [32:20] token_length, [33] last_in_step, [39:34] zero
  output logic [39:0]      m_axis_tdata,
  output logic [3:0]       m_axis_tuser,   // [3:0] token_class
  output logic             m_axis_tlast    // last_of_query
);

  localparam int unsigned PW = $clog2(MAX_QUERY_LEN + 1);
  localparam int unsigned START_CAP = (MAX_QUERY_LEN - 1 < 4095) ? MAX_QUERY_LEN - 1 : 4095;
  localparam int unsigned LEN_CAP = (MAX_QUERY_LEN < 8191) ? MAX_QUERY_LEN : 8191;
  localparam int unsigned POS_CAP = MAX_QUERY_LEN;
  localparam int unsigned NCAND = 6;

  sql_lex_pkg::word_t word_q, word_d;
  sql_lex_pkg::pend_e pend_q, pend_d;
  logic [PW-1:0]      pos_q, pos_d;
  sql_lex_pkg::tok_t  q_q [sql_lex_pkg::OUT_DEPTH];
  sql_lex_pkg::tok_t  q_d [sql_lex_pkg::OUT_DEPTH];
  logic [1:0]         cnt_q, cnt_d;
  sql_lex_pkg::tok_t  res0, res1;
  logic [1:0]         res_n;
  logic               accept, pop;

  // ---------------------------------------------------------------- helpers

  function automatic logic [sql_lex_pkg::START_W-1:0] cap_start(input logic [PW-1:0] p);
    if (32'(p) > START_CAP) begin
      return sql_lex_pkg::START_W'(START_CAP);
    end
    return sql_lex_pkg::START_W'(p);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    return (b inside {[8'h61:8'h7A]}) ? b - 8'h20 : b;
  endfunction

  function automatic sql_lex_pkg::word_t word_clear();
    sql_lex_pkg::word_t w;
    w.mode   = sql_lex_pkg::MODE_IDLE;
    w.prefix = '0;
    w.len    = '0;
    w.start  = '0;
    w.digits = 1'b1;
    w.ident  = 1'b1;
    return w;
  endfunction

  function automatic sql_lex_pkg::tok_t mk(input logic [3:0] cls, input logic [3:0] kw,
                                           input logic [3:0] op,
                                           input logic [sql_lex_pkg::START_W-1:0] start,
                                           input logic [sql_lex_pkg::LEN_W-1:0] len);
    sql_lex_pkg::tok_t t;
    t.cls        = cls;
    t.kw         = kw;
    t.op         = op;
    t.start      = start;
    t.len        = len;
    t.last_query = 1'b0;
    t.last_step  = 1'b0;
    return t;
  endfunction

  function automatic sql_lex_pkg::word_t word_add(input sql_lex_pkg::word_t wi,
                                                  input logic [7:0] b,
                                                  input logic [PW-1:0] at);
    sql_lex_pkg::word_t w;
    w = wi;
    if (w.mode != sql_lex_pkg::MODE_WORD) begin
      w       = word_clear();
      w.mode  = sql_lex_pkg::MODE_WORD;
      w.start = cap_start(at);
    end
    for (int i = 0; i < sql_lex_pkg::PREFIX_N; i++) begin
      if (32'(w.len) == i) begin
        w.prefix[8*sql_lex_pkg::PREFIX_N-1-8*i -: 8] = to_upper(b);
      end
    end
    if (w.len == '0) begin
      w.ident = is_alpha(b) || (b == sql_lex_pkg::CH_UNDER);
    end else begin
      w.ident = w.ident && (is_alpha(b) || is_digit(b) || (b == sql_lex_pkg::CH_UNDER));
    end
    w.digits = w.digits && is_digit(b);
    if (32'(w.len) < LEN_CAP) begin
      w.len = w.len + 1'b1;
    end
    return w;
  endfunction

  // token for the pending word or string; valid is low when nothing is open
  function automatic sql_lex_pkg::tok_t flush(input sql_lex_pkg::word_t w, output logic valid);
    logic        hit;
    logic [3:0]  kw;
    logic [3:0]  cls;
    hit = 1'b0;
    kw  = '0;
    for (int k = 0; k < sql_lex_pkg::KW_N; k++) begin
      if (w.len == sql_lex_pkg::KW_LEN[k] && w.prefix == sql_lex_pkg::KW_TEXT[k]) begin
        hit = 1'b1;
        kw  = 4'(k);
      end
    end
    valid = (w.mode == sql_lex_pkg::MODE_WORD) || (w.mode == sql_lex_pkg::MODE_STR);
    if (w.mode == sql_lex_pkg::MODE_STR) begin
      return mk(sql_lex_pkg::CLS_STR, '0, '0, w.start, w.len);
    end
    if (hit) begin
      return mk(sql_lex_pkg::CLS_KW, kw, '0, w.start, w.len);
    end
    if (w.len == sql_lex_pkg::LEN_W'(1) &&
        w.prefix[8*sql_lex_pkg::PREFIX_N-1 -: 8] == sql_lex_pkg::CH_PCT) begin
      return mk(sql_lex_pkg::CLS_OP, '0, sql_lex_pkg::OP_MOD, w.start, w.len);
    end
    if (w.digits) begin
      cls = sql_lex_pkg::CLS_NUM;
    end else if (w.ident) begin
      cls = sql_lex_pkg::CLS_IDENT;
    end else begin
      cls = sql_lex_pkg::CLS_UNKNOWN;
    end
    return mk(cls, '0, '0, w.start, w.len);
  endfunction

  function automatic sql_lex_pkg::tok_t single_op(input sql_lex_pkg::pend_e p,
                                                  input logic [PW-1:0] at);
    logic [3:0] id;
    case (p)
      sql_lex_pkg::PEND_LT: id = sql_lex_pkg::OP_LT;
      sql_lex_pkg::PEND_GT: id = sql_lex_pkg::OP_GT;
      default:              id = sql_lex_pkg::OP_EQ;
    endcase
    return mk(sql_lex_pkg::CLS_OP, '0, id, cap_start(at), sql_lex_pkg::LEN_W'(1));
  endfunction

  // ---------------------------------------------------------------- lexer pass

  always_comb begin
    sql_lex_pkg::word_t w;
    sql_lex_pkg::pend_e pend;
    sql_lex_pkg::tok_t  cand [NCAND];
    logic [NCAND-1:0]   cv;
    logic [7:0]         b;
    logic [PW-1:0]      pos;
    logic [PW-1:0]      prev;
    logic               consumed;
    logic               fv;
    logic [1:0]         n;

    w        = word_q;
    pend     = pend_q;
    pos      = pos_q;
    b        = s_axis_tdata;
    prev     = (pos_q != '0) ? pos_q - 1'b1 : '0;
    consumed = 1'b0;
    cv       = '0;
    fv       = 1'b0;
    for (int i = 0; i < NCAND; i++) begin
      cand[i] = '0;
    end

    // string body, or resolve the lookahead byte
    if (w.mode == sql_lex_pkg::MODE_STR) begin
      if (32'(w.len) < LEN_CAP) begin
        w.len = w.len + 1'b1;
      end
      if (b == sql_lex_pkg::CH_QUOTE) begin
        cand[0] = flush(w, fv);
        cv[0]   = fv;
        w       = word_clear();
      end
      consumed = 1'b1;
    end else if (pend == sql_lex_pkg::PEND_BANG) begin
      pend = sql_lex_pkg::PEND_NONE;
      if (b == sql_lex_pkg::CH_EQ) begin
        cand[0]  = flush(w, fv);
        cv[0]    = fv;
        w        = word_clear();
        cand[1]  = mk(sql_lex_pkg::CLS_OP, '0, sql_lex_pkg::OP_NE, cap_start(prev),
                      sql_lex_pkg::LEN_W'(2));
        cv[1]    = 1'b1;
        consumed = 1'b1;
      end else begin
        w = word_add(w, sql_lex_pkg::CH_BANG, prev);
      end
    end else if (pend != sql_lex_pkg::PEND_NONE) begin
      cv[0] = 1'b1;
      if (b == sql_lex_pkg::CH_EQ) begin
        case (pend)
          sql_lex_pkg::PEND_LT: cand[0] = mk(sql_lex_pkg::CLS_OP, '0, sql_lex_pkg::OP_LE,
                                             cap_start(prev), sql_lex_pkg::LEN_W'(2));
          sql_lex_pkg::PEND_GT: cand[0] = mk(sql_lex_pkg::CLS_OP, '0, sql_lex_pkg::OP_GE,
                                             cap_start(prev), sql_lex_pkg::LEN_W'(2));
          default:              cand[0] = mk(sql_lex_pkg::CLS_UNKNOWN, '0, '0,
                                             cap_start(prev), sql_lex_pkg::LEN_W'(2));
        endcase
        consumed = 1'b1;
      end else begin
        cand[0] = single_op(pend, prev);
      end
      pend = sql_lex_pkg::PEND_NONE;
    end

    // the byte itself
    if (!consumed) begin
      if (is_space(b)) begin
        cand[2] = flush(w, fv);
        cv[2]   = fv;
        w       = word_clear();
      end else if (b == sql_lex_pkg::CH_QUOTE) begin
        cand[2] = flush(w, fv);
        cv[2]   = fv;
        w       = word_clear();
        w.mode  = sql_lex_pkg::MODE_STR;
        w.start = cap_start(pos);
        w.len   = sql_lex_pkg::LEN_W'(1);
      end else if (b inside {sql_lex_pkg::CH_COMMA, sql_lex_pkg::CH_SEMI,
                             sql_lex_pkg::CH_LPAREN, sql_lex_pkg::CH_RPAREN,
                             sql_lex_pkg::CH_PLUS, sql_lex_pkg::CH_MINUS,
                             sql_lex_pkg::CH_STAR, sql_lex_pkg::CH_SLASH}) begin
        cand[2] = flush(w, fv);
        cv[2]   = fv;
        w       = word_clear();
        cv[3]   = 1'b1;
        case (b)
          sql_lex_pkg::CH_COMMA:  cand[3] = mk(sql_lex_pkg::CLS_COMMA, '0, '0,
                                               cap_start(pos), sql_lex_pkg::LEN_W'(1));
          sql_lex_pkg::CH_SEMI:   cand[3] = mk(sql_lex_pkg::CLS_SEMI, '0, '0,
                                               cap_start(pos), sql_lex_pkg::LEN_W'(1));
          sql_lex_pkg::CH_LPAREN: cand[3] = mk(sql_lex_pkg::CLS_LPAREN, '0, '0,
                                               cap_start(pos), sql_lex_pkg::LEN_W'(1));
          sql_lex_pkg::CH_RPAREN: cand[3] = mk(sql_lex_pkg::CLS_RPAREN, '0, '0,
                                               cap_start(pos), sql_lex_pkg::LEN_W'(1));
          sql_lex_pkg::CH_PLUS:   cand[3] = mk(sql_lex_pkg::CLS_OP, '0, sql_lex_pkg::OP_ADD,
                                               cap_start(pos), sql_lex_pkg::LEN_W'(1));
          sql_lex_pkg::CH_MINUS:  cand[3] = mk(sql_lex_pkg::CLS_OP, '0, sql_lex_pkg::OP_SUB,
                                               cap_start(pos), sql_lex_pkg::LEN_W'(1));
          sql_lex_pkg::CH_STAR:   cand[3] = mk(sql_lex_pkg::CLS_OP, '0, sql_lex_pkg::OP_MUL,
                                               cap_start(pos), sql_lex_pkg::LEN_W'(1));
          default:                cand[3] = mk(sql_lex_pkg::CLS_OP, '0, sql_lex_pkg::OP_DIV,
                                               cap_start(pos), sql_lex_pkg::LEN_W'(1));
        endcase
      end else if (b inside {sql_lex_pkg::CH_LT, sql_lex_pkg::CH_GT, sql_lex_pkg::CH_EQ}) begin
        cand[2] = flush(w, fv);
        cv[2]   = fv;
        w       = word_clear();
        case (b)
          sql_lex_pkg::CH_LT: pend = sql_lex_pkg::PEND_LT;
          sql_lex_pkg::CH_GT: pend = sql_lex_pkg::PEND_GT;
          default:            pend = sql_lex_pkg::PEND_EQ;
        endcase
      end else if (b == sql_lex_pkg::CH_BANG) begin
        pend = sql_lex_pkg::PEND_BANG;
      end else begin
        w = word_add(w, b, pos);
      end
    end

    // end of query: flush lookahead and word
    if (s_axis_tlast) begin
      if (pend == sql_lex_pkg::PEND_BANG) begin
        w = word_add(w, sql_lex_pkg::CH_BANG, pos);
      end else if (pend != sql_lex_pkg::PEND_NONE) begin
        cand[4] = single_op(pend, pos);
        cv[4]   = 1'b1;
      end
      pend    = sql_lex_pkg::PEND_NONE;
      cand[5] = flush(w, fv);
      cv[5]   = fv;
      w       = word_clear();
      pos_d   = '0;
    end else if (32'(pos_q) < POS_CAP) begin
      pos_d = pos_q + 1'b1;
    end else begin
      pos_d = pos_q;
    end

    // keep the first two tokens in order
    n    = '0;
    res0 = '0;
    res1 = '0;
    for (int i = 0; i < NCAND; i++) begin
      if (cv[i]) begin
        if (n == 2'd0) begin
          res0 = cand[i];
        end else if (n == 2'd1) begin
          res1 = cand[i];
        end
        if (n != 2'd2) begin
          n = n + 2'd1;
        end
      end
    end
    if (s_axis_tlast && n == 2'd0) begin
      res0 = mk(sql_lex_pkg::CLS_END, '0, '0, cap_start(pos), '0);
      n    = 2'd1;
    end
    if (n == 2'd1) begin
      res0.last_step  = 1'b1;
      res0.last_query = s_axis_tlast;
    end else if (n == 2'd2) begin
      res1.last_step  = 1'b1;
      res1.last_query = s_axis_tlast;
    end

    res_n  = n;
    word_d = w;
    pend_d = pend;
  end

  // ---------------------------------------------------------------- token queue

  assign s_axis_tready = (cnt_q <= 2'd1);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_comb begin
    sql_lex_pkg::tok_t shifted [sql_lex_pkg::OUT_DEPTH];
    logic [1:0] base;
    logic [1:0] npush;

    // drop the head on a transfer, then append behind what is left
    if (pop) begin
      shifted[0] = q_q[1];
      shifted[1] = q_q[2];
      shifted[2] = q_q[2];
    end else begin
      shifted[0] = q_q[0];
      shifted[1] = q_q[1];
      shifted[2] = q_q[2];
    end
    base  = cnt_q - {1'b0, pop};
    npush = accept ? res_n : 2'd0;
    for (int i = 0; i < sql_lex_pkg::OUT_DEPTH; i++) begin
      q_d[i] = shifted[i];
      if (npush != 2'd0 && 2'(i) == base) begin
        q_d[i] = res0;
      end
      if (npush == 2'd2 && 2'(i) == base + 2'd1) begin
        q_d[i] = res1;
      end
    end
    cnt_d = base + npush;
  end

  assign m_axis_tuser = q_q[0].cls;
  assign m_axis_tlast = q_q[0].last_query;
  assign m_axis_tdata = {6'b0, q_q[0].last_step, q_q[0].len, q_q[0].start,
                         q_q[0].op, q_q[0].kw};

  // ---------------------------------------------------------------- registers

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= word_clear();
      pend_q <= sql_lex_pkg::PEND_NONE;
      pos_q  <= '0;
      cnt_q  <= '0;
    end else begin
      if (accept) begin
        word_q <= word_d;
        pend_q <= pend_d;
        pos_q  <= pos_d;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < sql_lex_pkg::OUT_DEPTH; i++) begin
      q_q[i] <= q_d[i];
    end
  end

`ifndef NO_ASSERTIONS
  // the closing byte of a query always leaves a token queued
  a_eoq_yields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
    else $error("query end produced no token");

  // the last token of a query is also the last of its byte
  a_last_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[33])
    else $error("last_of_query without last_in_step");

  // a string never coexists with operator lookahead
  a_str_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_q.mode == sql_lex_pkg::MODE_STR |-> pend_q == sql_lex_pkg::PEND_NONE)
    else $error("lookahead pending inside a string");

  // position counter stays within its saturation bound
  a_pos_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) <= POS_CAP)
    else $error("byte position past its cap");
`endif

endmodule

`default_nettype wire

// ----- tb/sql_query_lexer_checker.sv -----
// Scoreboard for the SQL lexer: watches both stream channels, predicts tokens per byte.
// Uses sql_lex_pkg for the token record, lexer modes and character and class codes.
module sql_query_lexer_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,
  input  logic              s_axis_tlast,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [39:0]       m_axis_tdata,
  input  logic [3:0]        m_axis_tuser,
  input  logic              m_axis_tlast,
  output int unsigned       fail_count_o,
  output int unsigned       due_count_o,
  output int unsigned       token_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QLEN = sql_lex_pkg::MAX_QUERY_LEN_DEF;
  localparam int unsigned START_CAP = (QLEN - 1 < 4095) ? QLEN - 1 : 4095;
  localparam int unsigned LEN_CAP = (QLEN < 8191) ? QLEN : 8191;
  localparam int unsigned POS_CAP = QLEN;
  localparam logic [3:0] NO_ID = 4'd0;

  // lexer state as the block should hold it
  sql_lex_pkg::mode_e  lx_mode;
  sql_lex_pkg::pend_e  lx_pend;
  logic [7:0]          lx_prefix [sql_lex_pkg::PREFIX_N];
  int unsigned         lx_len;
  int unsigned         lx_start;
  int unsigned         lx_pos;
  bit                  lx_digits;
  bit                  lx_ident;

  sql_lex_pkg::tok_t   step_tok [2];
  int unsigned         step_n;
  sql_lex_pkg::tok_t   tokens_due [$];
  int unsigned         mismatches;
  int unsigned         tokens_seen;

  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic bit is_space(logic [7:0] b);
    return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic int unsigned sat_start(int unsigned p);
    return (p > START_CAP) ? START_CAP : p;
  endfunction

  function automatic void clear_word();
    lx_mode = sql_lex_pkg::MODE_IDLE;
    foreach (lx_prefix[i]) lx_prefix[i] = 8'h00;
    lx_len = 0;
    lx_start = 0;
    lx_digits = 1'b1;
    lx_ident = 1'b1;
  endfunction

  function automatic void reset_lexer();
    clear_word();
    lx_pend = sql_lex_pkg::PEND_NONE;
    lx_pos = 0;
  endfunction

  function automatic void add_tok(logic [3:0] cls, logic [3:0] kw, logic [3:0] op,
                                  int unsigned start, int unsigned len);
    sql_lex_pkg::tok_t t;
    if (step_n >= 2) return;
    t = '0;
    t.cls = cls;
    t.kw = kw;
    t.op = op;
    t.start = sql_lex_pkg::START_W'(sat_start(start));
    t.len = sql_lex_pkg::LEN_W'((len > LEN_CAP) ? LEN_CAP : len);
    step_tok[step_n] = t;
    step_n++;
  endfunction

  function automatic void grow_word(logic [7:0] b, int unsigned at);
    bit word_char;
    word_char = is_alpha(b) || is_digit(b) || b == sql_lex_pkg::CH_UNDER;
    if (lx_mode != sql_lex_pkg::MODE_WORD) begin
      clear_word();
      lx_mode = sql_lex_pkg::MODE_WORD;
      lx_start = sat_start(at);
    end
    if (lx_len < sql_lex_pkg::PREFIX_N)
      lx_prefix[lx_len] = (b >= "a" && b <= "z") ? b - 8'h20 : b;
    if (lx_len == 0) lx_ident = is_alpha(b) || b == sql_lex_pkg::CH_UNDER;
    else lx_ident = lx_ident && word_char;
    lx_digits = lx_digits && is_digit(b);
    if (lx_len < LEN_CAP) lx_len++;
  endfunction

  // keyword index of the held word, or -1
  function automatic int keyword_match();
    logic [47:0] w;
    w = {lx_prefix[0], lx_prefix[1], lx_prefix[2], lx_prefix[3], lx_prefix[4], lx_prefix[5]};
    if (lx_len > sql_lex_pkg::PREFIX_N) return -1;
    case ({lx_len[2:0], w})
      {3'd6, "SELECT"}:        return 0;
      {3'd4, "FROM", 16'h0}:   return 1;
      {3'd5, "WHERE", 8'h0}:   return 2;
      {3'd6, "INSERT"}:        return 3;
      {3'd6, "UPDATE"}:        return 4;
      {3'd6, "DELETE"}:        return 5;
      {3'd5, "ORDER", 8'h0}:   return 6;
      {3'd2, "BY", 32'h0}:     return 7;
      {3'd3, "ASC", 24'h0}:    return 8;
      {3'd4, "DESC", 16'h0}:   return 9;
      {3'd5, "LIMIT", 8'h0}:   return 10;
      {3'd4, "INTO", 16'h0}:   return 11;
      {3'd6, "VALUES"}:        return 12;
      {3'd3, "SET", 24'h0}:    return 13;
      {3'd3, "AND", 24'h0}:    return 14;
      {3'd2, "OR", 32'h0}:     return 15;
      default:                 return -1;
    endcase
  endfunction

  function automatic void close_word();
    int id;
    if (lx_mode == sql_lex_pkg::MODE_STR) begin
      add_tok(sql_lex_pkg::CLS_STR, NO_ID, NO_ID, lx_start, lx_len);
      clear_word();
      return;
    end
    if (lx_mode != sql_lex_pkg::MODE_WORD) return;
    id = keyword_match();
    if (id >= 0)
      add_tok(sql_lex_pkg::CLS_KW, 4'(id), NO_ID, lx_start, lx_len);
    else if (lx_len == 1 && lx_prefix[0] == sql_lex_pkg::CH_PCT)
      add_tok(sql_lex_pkg::CLS_OP, NO_ID, sql_lex_pkg::OP_MOD, lx_start, 1);
    else if (lx_digits)
      add_tok(sql_lex_pkg::CLS_NUM, NO_ID, NO_ID, lx_start, lx_len);
    else if (lx_ident)
      add_tok(sql_lex_pkg::CLS_IDENT, NO_ID, NO_ID, lx_start, lx_len);
    else
      add_tok(sql_lex_pkg::CLS_UNKNOWN, NO_ID, NO_ID, lx_start, lx_len);
    clear_word();
  endfunction

  function automatic void single_op(sql_lex_pkg::pend_e p, int unsigned at);
    logic [3:0] id;
    case (p)
      sql_lex_pkg::PEND_LT: id = sql_lex_pkg::OP_LT;
      sql_lex_pkg::PEND_GT: id = sql_lex_pkg::OP_GT;
      default:              id = sql_lex_pkg::OP_EQ;
    endcase
    add_tok(sql_lex_pkg::CLS_OP, NO_ID, id, at, 1);
  endfunction

  // advance the lexer by one byte and queue the tokens it yields
  function automatic void lex_byte(logic [7:0] b, logic eoq);
    int unsigned at;
    int unsigned prv;
    bit used;
    sql_lex_pkg::pend_e p;
    logic [3:0] cls;
    logic [3:0] op;
    at = lx_pos;
    prv = (at > 0) ? at - 1 : 0;
    used = 1'b0;
    step_n = 0;

    if (lx_mode == sql_lex_pkg::MODE_STR) begin
      if (lx_len < LEN_CAP) lx_len++;
      if (b == sql_lex_pkg::CH_QUOTE) close_word();
      used = 1'b1;
    end else if (lx_pend == sql_lex_pkg::PEND_BANG) begin
      lx_pend = sql_lex_pkg::PEND_NONE;
      if (b == sql_lex_pkg::CH_EQ) begin
        close_word();
        add_tok(sql_lex_pkg::CLS_OP, NO_ID, sql_lex_pkg::OP_NE, prv, 2);
        used = 1'b1;
      end else begin
        grow_word(sql_lex_pkg::CH_BANG, prv);
      end
    end else if (lx_pend != sql_lex_pkg::PEND_NONE) begin
      p = lx_pend;
      lx_pend = sql_lex_pkg::PEND_NONE;
      if (b == sql_lex_pkg::CH_EQ) begin
        if (p == sql_lex_pkg::PEND_LT)
          add_tok(sql_lex_pkg::CLS_OP, NO_ID, sql_lex_pkg::OP_LE, prv, 2);
        else if (p == sql_lex_pkg::PEND_GT)
          add_tok(sql_lex_pkg::CLS_OP, NO_ID, sql_lex_pkg::OP_GE, prv, 2);
        else
          add_tok(sql_lex_pkg::CLS_UNKNOWN, NO_ID, NO_ID, prv, 2);
        used = 1'b1;
      end else begin
        single_op(p, prv);
      end
    end

    if (!used) begin
      if (is_space(b)) begin
        close_word();
      end else begin
        case (b)
          sql_lex_pkg::CH_QUOTE: begin
            close_word();
            clear_word();
            lx_mode = sql_lex_pkg::MODE_STR;
            lx_start = sat_start(at);
            lx_len = 1;
          end
          sql_lex_pkg::CH_COMMA, sql_lex_pkg::CH_SEMI,
          sql_lex_pkg::CH_LPAREN, sql_lex_pkg::CH_RPAREN: begin
            close_word();
            cls = (b == sql_lex_pkg::CH_COMMA) ? sql_lex_pkg::CLS_COMMA :
                  (b == sql_lex_pkg::CH_SEMI) ? sql_lex_pkg::CLS_SEMI :
                  (b == sql_lex_pkg::CH_LPAREN) ? sql_lex_pkg::CLS_LPAREN :
                  sql_lex_pkg::CLS_RPAREN;
            add_tok(cls, NO_ID, NO_ID, at, 1);
          end
          sql_lex_pkg::CH_PLUS, sql_lex_pkg::CH_MINUS,
          sql_lex_pkg::CH_STAR, sql_lex_pkg::CH_SLASH: begin
            close_word();
            op = (b == sql_lex_pkg::CH_PLUS) ? sql_lex_pkg::OP_ADD :
                 (b == sql_lex_pkg::CH_MINUS) ? sql_lex_pkg::OP_SUB :
                 (b == sql_lex_pkg::CH_STAR) ? sql_lex_pkg::OP_MUL : sql_lex_pkg::OP_DIV;
            add_tok(sql_lex_pkg::CLS_OP, NO_ID, op, at, 1);
          end
          sql_lex_pkg::CH_LT, sql_lex_pkg::CH_GT, sql_lex_pkg::CH_EQ: begin
            close_word();
            case (b)
              sql_lex_pkg::CH_LT: lx_pend = sql_lex_pkg::PEND_LT;
              sql_lex_pkg::CH_GT: lx_pend = sql_lex_pkg::PEND_GT;
              default:            lx_pend = sql_lex_pkg::PEND_EQ;
            endcase
          end
          sql_lex_pkg::CH_BANG: lx_pend = sql_lex_pkg::PEND_BANG;
          default: grow_word(b, at);
        endcase
      end
    end

    if (eoq) begin
      if (lx_pend == sql_lex_pkg::PEND_BANG) grow_word(sql_lex_pkg::CH_BANG, at);
      else if (lx_pend != sql_lex_pkg::PEND_NONE) single_op(lx_pend, at);
      lx_pend = sql_lex_pkg::PEND_NONE;
      close_word();
      if (step_n == 0) add_tok(sql_lex_pkg::CLS_END, NO_ID, NO_ID, at, 0);
      step_tok[step_n - 1].last_query = 1'b1;
      clear_word();
      lx_pos = 0;
    end else if (lx_pos < POS_CAP) begin
      lx_pos++;
    end

    if (step_n > 0) step_tok[step_n - 1].last_step = 1'b1;
    for (int i = 0; i < step_n; i++) tokens_due = {tokens_due, step_tok[i]};
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $error("token %0d %s: expected %0d, got %0d", tokens_seen, name, want, got);
    end
  endfunction

  function automatic void check_token();
    sql_lex_pkg::tok_t want;
    tokens_seen++;
    if (tokens_due.size() == 0) begin
      mismatches++;
      $error("token %0d arrived with none expected: class %0d start %0d", tokens_seen,
             m_axis_tuser, m_axis_tdata[19:8]);
      return;
    end
    want = tokens_due.pop_front();
    compare_field("token_class", 16'(want.cls), 16'(m_axis_tuser));
    compare_field("keyword_id", 16'(want.kw), 16'(m_axis_tdata[3:0]));
    compare_field("operator_id", 16'(want.op), 16'(m_axis_tdata[7:4]));
    compare_field("start_offset", 16'(want.start), 16'(m_axis_tdata[19:8]));
    compare_field("token_length", 16'(want.len), 16'(m_axis_tdata[32:20]));
    compare_field("last_in_step", 16'(want.last_step), 16'(m_axis_tdata[33]));
    compare_field("last_of_query", 16'(want.last_query), 16'(m_axis_tlast));
    compare_field("tdata_pad", 16'h0, 16'(m_axis_tdata[39:34]));
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      reset_lexer();
      tokens_due.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) lex_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_token();
    end
    fail_count_o <= mismatches;
    due_count_o <= tokens_due.size();
    token_count_o <= tokens_seen;
  end

endmodule

// ----- tb/tb_sql_query_lexer_unit.sv -----
// Top of the SQL lexer bench: clock, reset, query byte stimulus and output backpressure.
// Instantiates sql_query_lexer_unit and sql_query_lexer_checker; uses sql_lex_pkg.
module tb_sql_query_lexer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD = 10;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned BYTE_TARGET = 1450;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int unsigned fail_count;
  int unsigned due_count;
  int unsigned token_count;
  int unsigned src_idle = 34;
  int unsigned snk_idle = 59;
  int unsigned bytes_sent = 0;
  int unsigned queries_sent = 0;
  int unsigned cycles = 0;
  logic [7:0]  query_text [$];

  sql_query_lexer_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  sql_query_lexer_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .due_count_o   (due_count),
    .token_count_o (token_count)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= (snk_idle == 0) || ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sql_query_lexer_unit verification failed");
      $finish;
    end
  end

  // append one byte to the query under construction
  function automatic void append_char(logic [7:0] c);
    query_text = {query_text, c};
  endfunction

  function automatic logic [7:0] any_letter();
    int unsigned r;
    r = $urandom_range(51);
    return (r < 26) ? 8'h41 + 8'(r) : 8'h61 + 8'(r - 26);
  endfunction

  function automatic logic [7:0] any_space();
    return ($urandom_range(5) == 0) ? 8'($urandom_range(9, 13)) : 8'h20;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(3))
      0: return 8'($urandom_range(255));
      1: return 8'($urandom_range(128, 255));
      2: return 8'($urandom_range(31));
      default: begin
        case ($urandom_range(7))
          0: return sql_lex_pkg::CH_QUOTE;
          1: return sql_lex_pkg::CH_BANG;
          2: return sql_lex_pkg::CH_EQ;
          3: return sql_lex_pkg::CH_LT;
          4: return sql_lex_pkg::CH_GT;
          5: return sql_lex_pkg::CH_PCT;
          6: return sql_lex_pkg::CH_UNDER;
          default: return sql_lex_pkg::CH_SEMI;
        endcase
      end
    endcase
  endfunction

  // keyword text, sometimes cut short by one letter or grown by one
  task automatic add_keyword();
    int unsigned k;
    int unsigned n;
    int unsigned tweak;
    logic [7:0] c;
    k = $urandom_range(sql_lex_pkg::KW_N - 1);
    n = sql_lex_pkg::KW_LEN[k];
    tweak = $urandom_range(5);
    if (tweak == 0) n--;
    for (int i = 0; i < n; i++) begin
      c = sql_lex_pkg::KW_TEXT[k][8 * (sql_lex_pkg::PREFIX_N - 1 - i) +: 8];
      append_char($urandom_range(1) ? c + 8'h20 : c);
    end
    if (tweak == 1) append_char(any_letter());
  endtask

  task automatic add_ident();
    int unsigned n;
    int unsigned r;
    n = $urandom_range(8);
    append_char(($urandom_range(4) == 0) ? sql_lex_pkg::CH_UNDER : any_letter());
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(9);
      if (r < 6) append_char(any_letter());
      else if (r < 9) append_char(8'h30 + 8'($urandom_range(9)));
      else append_char(sql_lex_pkg::CH_UNDER);
    end
  endtask

  task automatic add_string();
    int unsigned n;
    logic [7:0] c;
    n = $urandom_range(8);
    append_char(sql_lex_pkg::CH_QUOTE);
    for (int i = 0; i < n; i++) begin
      c = 8'($urandom_range(32, 126));
      append_char((c == sql_lex_pkg::CH_QUOTE) ? 8'h20 : c);
    end
    append_char(sql_lex_pkg::CH_QUOTE);
  endtask

  task automatic add_operator();
    case ($urandom_range(11))
      0: append_char(sql_lex_pkg::CH_PLUS);
      1: append_char(sql_lex_pkg::CH_MINUS);
      2: append_char(sql_lex_pkg::CH_STAR);
      3: append_char(sql_lex_pkg::CH_SLASH);
      4: append_char(sql_lex_pkg::CH_EQ);
      5: begin
        append_char(sql_lex_pkg::CH_BANG);
        append_char(sql_lex_pkg::CH_EQ);
      end
      6: append_char(sql_lex_pkg::CH_LT);
      7: append_char(sql_lex_pkg::CH_GT);
      8: begin
        append_char(sql_lex_pkg::CH_LT);
        append_char(sql_lex_pkg::CH_EQ);
      end
      9: begin
        append_char(sql_lex_pkg::CH_GT);
        append_char(sql_lex_pkg::CH_EQ);
      end
      10: begin
        append_char(sql_lex_pkg::CH_EQ);
        append_char(sql_lex_pkg::CH_EQ);
      end
      default: append_char(sql_lex_pkg::CH_PCT);
    endcase
  endtask

  task automatic add_piece();
    int unsigned n;
    case ($urandom_range(19))
      0, 1, 2, 3, 18, 19: add_keyword();
      4, 5, 6: add_ident();
      7, 8: begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) append_char(8'h30 + 8'($urandom_range(9)));
      end
      9, 10: add_string();
      11, 12, 13: add_operator();
      14, 15, 16: begin
        case ($urandom_range(3))
          0: append_char(sql_lex_pkg::CH_COMMA);
          1: append_char(sql_lex_pkg::CH_SEMI);
          2: append_char(sql_lex_pkg::CH_LPAREN);
          default: append_char(sql_lex_pkg::CH_RPAREN);
        endcase
      end
      default: append_char(noise_byte());
    endcase
  endtask

  // mostly SQL-like token runs, now and then pure noise or an unclosed string
  task automatic build_query();
    int unsigned pieces;
    query_text.delete();
    if ($urandom_range(9) == 0) begin
      pieces = $urandom_range(1, 16);
      for (int i = 0; i < pieces; i++) append_char(noise_byte());
    end else begin
      pieces = $urandom_range(1, 10);
      for (int i = 0; i < pieces; i++) begin
        add_piece();
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: append_char(any_space());
          9: begin
            append_char(any_space());
            append_char(any_space());
          end
          default: ;
        endcase
      end
      if ($urandom_range(9) == 0) begin
        append_char(sql_lex_pkg::CH_QUOTE);
        append_char(any_letter());
        append_char(8'h20);
      end
    end
  endtask

  // enter and leave at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic eoq);
    while (src_idle != 0 && $urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= eoq;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_query();
    for (int i = 0; i < query_text.size(); i++)
      push_byte(query_text[i], i == query_text.size() - 1);
    queries_sent++;
  endtask

  task automatic send_text(input string txt);
    query_text.delete();
    for (int i = 0; i < txt.len(); i++) append_char(txt[i]);
    send_query();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // keyword case, bang-equals ending a number, a joined compare
    send_text("Or 5!=x>=y");
    // bang inside a word, double equals, plus, minus, star and slash, equals at the end
    send_text("(a!)==+-*/=");
    // lone percent, quote ending a word, string left open at the end
    send_text("%;x'q r");
    // high byte and control byte as a word, lone less-than, trailing bang
    query_text = '{8'hFF, 8'h00, sql_lex_pkg::CH_LT, sql_lex_pkg::CH_BANG};
    send_query();
    // nothing but whitespace: only the end marker
    send_text(" ");

    while (bytes_sent < BYTE_TARGET) begin
      if (bytes_sent >= 2 * BYTE_TARGET / 3) begin
        src_idle = 0;
        snk_idle = 0;
      end else if (bytes_sent >= BYTE_TARGET / 3) begin
        src_idle = 59;
        snk_idle = 34;
      end
      build_query();
      send_query();
    end

    s_axis_tvalid <= 1'b0;
    while (due_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Lexed %0d queries (%0d bytes) under shifting backpressure; %0d tokens compared.",
             queries_sent, bytes_sent, token_count);
    if (fail_count == 0 && due_count == 0) begin
      $display("sql_query_lexer_unit verification clean");
    end else begin
      $display("sql_query_lexer_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/sql_lex_pkg.sv
hdl/sql_query_lexer_unit.sv
tb/sql_query_lexer_checker.sv
tb/tb_sql_query_lexer_unit.sv
